// ===== rtl/core/dlft_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual LED flash/torch controller package
// Request and response types, action and status codes, current tables.
// ----------------------------------------------------------------------------
package dlft_pkg;

  localparam int CHANNELS      = 2;
  localparam int LEVEL_COUNT   = 28;
  localparam int TORCH_LEVELS  = 7;

  localparam logic [10:0] HW_TIMEOUT_MS  = 11'd400;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd100;
  localparam logic [15:0] TIMEOUT_MAX    = 16'hFFFF;

  // Enable register bits
  localparam logic [7:0] EN_TORCH_MODE = 8'h08;
  localparam logic [7:0] EN_FLASH_MODE = 8'h0C;
  localparam logic [7:0] EN_LED1       = 8'h01;
  localparam logic [7:0] EN_LED2       = 8'h02;

  typedef enum logic [3:0] {
    ACT_SET_TIMEOUT = 4'd0,
    ACT_SET_LEVEL   = 4'd1,
    ACT_ON          = 4'd2,
    ACT_OFF         = 4'd3,
    ACT_LEVEL_COUNT = 4'd4,
    ACT_MAX_TORCH   = 4'd5,
    ACT_CURRENT     = 4'd6,
    ACT_HW_TIMEOUT  = 4'd7,
    ACT_TICK        = 4'd8
  } action_e_t;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_CHAN   = 2'd1,
    STATUS_BAD_ACTION = 2'd2
  } status_e_t;

  typedef struct packed {
    logic [3:0]         action;
    logic [1:0]         channel;
    logic signed [31:0] value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [10:0] reply;
    logic [7:0]  enable_bits;
    logic [7:0]  torch_code;
    logic [7:0]  flash_code;
  } rsp_t;

  function automatic logic [7:0] torch_code_f(input logic [4:0] lvl);
    logic [7:0] code;
    unique case (lvl)
      5'd0:    code = 8'h0C;
      5'd1:    code = 8'h17;
      5'd2:    code = 8'h23;
      5'd3:    code = 8'h31;
      5'd4:    code = 8'h3B;
      5'd5:    code = 8'h47;
      5'd6:    code = 8'h53;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

  function automatic logic [7:0] flash_code_f(input logic [4:0] lvl);
    logic [7:0] code;
    unique case (lvl)
      5'd0:    code = 8'h03;
      5'd1:    code = 8'h05;
      5'd2:    code = 8'h08;
      5'd3:    code = 8'h0C;
      5'd4:    code = 8'h0E;
      5'd5:    code = 8'h12;
      5'd6:    code = 8'h14;
      5'd7:    code = 8'h19;
      5'd8:    code = 8'h1F;
      5'd9:    code = 8'h26;
      5'd10:   code = 8'h2C;
      5'd11:   code = 8'h32;
      5'd12:   code = 8'h38;
      5'd13:   code = 8'h40;
      5'd14:   code = 8'h46;
      5'd15:   code = 8'h4C;
      5'd16:   code = 8'h53;
      5'd17:   code = 8'h59;
      5'd18:   code = 8'h5F;
      5'd19:   code = 8'h65;
      5'd20:   code = 8'h6D;
      5'd21:   code = 8'h73;
      5'd22:   code = 8'h79;
      5'd23:   code = 8'h7F;
      5'd24:   code = 8'h86;
      5'd25:   code = 8'h8C;
      5'd26:   code = 8'h92;
      default: code = 8'h99;
    endcase
    return code;
  endfunction

  function automatic logic [10:0] milliamps_f(input logic [4:0] lvl);
    logic [10:0] ma;
    unique case (lvl)
      5'd0:    ma = 11'd24;
      5'd1:    ma = 11'd46;
      5'd2:    ma = 11'd70;
      5'd3:    ma = 11'd93;
      5'd4:    ma = 11'd116;
      5'd5:    ma = 11'd141;
      5'd6:    ma = 11'd164;
      5'd7:    ma = 11'd199;
      5'd8:    ma = 11'd246;
      5'd9:    ma = 11'd304;
      5'd10:   ma = 11'd351;
      5'd11:   ma = 11'd398;
      5'd12:   ma = 11'd445;
      5'd13:   ma = 11'd504;
      5'd14:   ma = 11'd551;
      5'd15:   ma = 11'd598;
      5'd16:   ma = 11'd656;
      5'd17:   ma = 11'd703;
      5'd18:   ma = 11'd750;
      5'd19:   ma = 11'd797;
      5'd20:   ma = 11'd856;
      5'd21:   ma = 11'd903;
      5'd22:   ma = 11'd949;
      5'd23:   ma = 11'd996;
      5'd24:   ma = 11'd1055;
      5'd25:   ma = 11'd1100;
      5'd26:   ma = 11'd1147;
      default: ma = 11'd1202;
    endcase
    return ma;
  endfunction

endpackage

// ===== rtl/core/dlft_cmd_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request input register
// Captures one request from the input channel and holds it until consumed.
// ----------------------------------------------------------------------------
module dlft_cmd_reg
  import dlft_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  cmd_t in_data,
  input  logic take,
  output logic cmd_valid,
  output cmd_t cmd
);

  logic valid_r;
  logic valid_nxt;
  cmd_t cmd_r;
  logic load;

  // Accept a new request when empty or when the held one leaves this cycle.
  assign in_stall  = valid_r && !take;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load || (valid_r && !take);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r <= in_data;
    end
  end

  assign cmd_valid = valid_r;
  assign cmd       = cmd_r;

endmodule

// ===== rtl/core/dlft_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Flash/torch control core
// Channel state, request decode and response build for one request a cycle while fire is high.
// ----------------------------------------------------------------------------
module dlft_core
  import dlft_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic fire,
  input  cmd_t cmd,
  output rsp_t rsp
);

  logic [7:0]  enable_r;
  logic [7:0]  enable_nxt;
  logic [4:0]  level_r     [CHANNELS];
  logic [4:0]  level_nxt   [CHANNELS];
  logic [15:0] timeout_r   [CHANNELS];
  logic [15:0] timeout_nxt [CHANNELS];
  logic [15:0] count_r     [CHANNELS];
  logic [15:0] count_nxt   [CHANNELS];
  logic        running_r   [CHANNELS];
  logic        running_nxt [CHANNELS];

  function automatic logic [7:0] led_bit_f(input logic ch);
    return ch ? EN_LED2 : EN_LED1;
  endfunction

  function automatic logic [7:0] led_off_f(input logic [7:0] img, input logic ch);
    logic [7:0] other;
    other = led_bit_f(!ch);
    if ((img & other) != 8'h00) begin
      return img & ~led_bit_f(ch);
    end
    return img & ~(EN_FLASH_MODE | led_bit_f(ch));
  endfunction

  function automatic logic [4:0] clamp_level_f(input logic [31:0] raw);
    if (raw[31]) begin
      return 5'd0;
    end
    if (raw >= 32'(LEVEL_COUNT)) begin
      return 5'(LEVEL_COUNT - 1);
    end
    return raw[4:0];
  endfunction

  always_comb begin
    logic        chan_ok;
    logic        ch;
    logic [31:0] val;
    logic [15:0] dec;
    logic [1:0]  status;
    logic [10:0] reply;
    logic [4:0]  lvl_out;

    chan_ok = cmd.channel < 2'(CHANNELS);
    ch      = cmd.channel[0];
    val     = $unsigned(cmd.value);
    status  = STATUS_OK;
    reply   = 11'd0;
    dec     = 16'd0;

    enable_nxt  = enable_r;
    level_nxt   = level_r;
    timeout_nxt = timeout_r;
    count_nxt   = count_r;
    running_nxt = running_r;

    if (cmd.action == ACT_TICK) begin
      // Channel 0 first: its turn-off affects how channel 1 clears mode bits.
      for (int i = 0; i < CHANNELS; i++) begin
        if (running_r[i]) begin
          dec          = count_r[i] - 16'd1;
          count_nxt[i] = dec;
          if (dec == 16'd0) begin
            running_nxt[i] = 1'b0;
            enable_nxt     = led_off_f(enable_nxt, 1'(i));
          end
        end
      end
    end else if (!chan_ok) begin
      status = STATUS_BAD_CHAN;
    end else begin
      unique case (action_e_t'(cmd.action))
        ACT_SET_TIMEOUT: begin
          if (val[31] || (val[30:16] != 15'd0)) begin
            timeout_nxt[ch] = TIMEOUT_MAX;
          end else begin
            timeout_nxt[ch] = val[15:0];
          end
        end
        ACT_SET_LEVEL: level_nxt[ch] = clamp_level_f(val);
        ACT_ON: begin
          if (timeout_r[ch] != 16'd0) begin
            count_nxt[ch]   = timeout_r[ch];
            running_nxt[ch] = 1'b1;
          end
          if (level_r[ch] < 5'(TORCH_LEVELS)) begin
            enable_nxt = enable_r | EN_TORCH_MODE | led_bit_f(ch);
          end else begin
            enable_nxt = enable_r | EN_FLASH_MODE | led_bit_f(ch);
          end
        end
        ACT_OFF: begin
          enable_nxt      = led_off_f(enable_r, ch);
          running_nxt[ch] = 1'b0;
          count_nxt[ch]   = 16'd0;
        end
        ACT_LEVEL_COUNT: reply = 11'(LEVEL_COUNT);
        ACT_MAX_TORCH:   reply = 11'(TORCH_LEVELS - 1);
        ACT_CURRENT:     reply = milliamps_f(clamp_level_f(val));
        ACT_HW_TIMEOUT:  reply = HW_TIMEOUT_MS;
        default:         status = STATUS_BAD_ACTION;
      endcase
    end

    lvl_out         = level_nxt[ch];
    rsp.status      = status;
    rsp.reply       = reply;
    rsp.enable_bits = enable_nxt;
    rsp.torch_code  = chan_ok ? torch_code_f(lvl_out) : 8'h00;
    rsp.flash_code  = chan_ok ? flash_code_f(lvl_out) : 8'h00;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 8'h00;
      for (int i = 0; i < CHANNELS; i++) begin
        level_r[i]   <= 5'd0;
        timeout_r[i] <= TIMEOUT_RESET;
        count_r[i]   <= 16'd0;
        running_r[i] <= 1'b0;
      end
    end else if (fire) begin
      enable_r  <= enable_nxt;
      level_r   <= level_nxt;
      timeout_r <= timeout_nxt;
      count_r   <= count_nxt;
      running_r <= running_nxt;
    end
  end

endmodule

// ===== rtl/core/dlft_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response output register
// Holds one response until the output channel takes it.
// ----------------------------------------------------------------------------
module dlft_out_reg
  import dlft_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  input  rsp_t rsp,
  output logic take,
  output logic fire,
  output logic out_valid,
  input  logic out_stall,
  output rsp_t out_data
);

  logic valid_r;
  logic valid_nxt;
  rsp_t rsp_r;

  // Free when empty or when the held response leaves this cycle.
  assign take      = !valid_r || !out_stall;
  assign fire      = cmd_valid && take;
  assign valid_nxt = fire || (valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_r <= rsp;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = rsp_r;

endmodule

// ===== rtl/core/dual_led_flash_torch_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual LED flash/torch controller
// Two-channel enable image, level tables and millisecond countdowns.
// ----------------------------------------------------------------------------
// Each request (action, channel, value) yields exactly one response. The
// request is held in the input register after it is accepted and moves
// through the decode logic into the output register when that register is
// free; out_valid then rises and the response leaves while out_stall is low.
// A request can be accepted every cycle; the channel state is updated as a
// request moves into the output register, so the next request already sees
// it. Throughput drops only while the output side holds out_stall. Tick
// requests advance both countdowns.
module dual_led_flash_torch_controller
  import dlft_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  cmd_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output rsp_t out_data
);

  logic take;
  logic fire;
  logic cmd_valid;
  cmd_t cmd;
  rsp_t rsp;

  dlft_cmd_reg u_cmd_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .take      (take),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  dlft_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .cmd   (cmd),
    .rsp   (rsp)
  );

  dlft_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .rsp       (rsp),
    .take      (take),
    .fire      (fire),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== tb/dual_led_flash_torch_controller_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dual LED flash/torch controller testbench
// Drives command requests through the valid/stall input channel, predicts
// every response from a local model of the enable image, levels, timeouts
// and countdowns, and checks each response field by field as it leaves the
// block. The input side idles and the output side stalls at random.
// ----------------------------------------------------------------------------
module dual_led_flash_torch_controller_tb;
  import dlft_pkg::*;

  localparam logic [10:0] MA_TABLE [LEVEL_COUNT] = '{
    11'd24,   11'd46,   11'd70,   11'd93,   11'd116,  11'd141,  11'd164,
    11'd199,  11'd246,  11'd304,  11'd351,  11'd398,  11'd445,  11'd504,
    11'd551,  11'd598,  11'd656,  11'd703,  11'd750,  11'd797,  11'd856,
    11'd903,  11'd949,  11'd996,  11'd1055, 11'd1100, 11'd1147, 11'd1202
  };
  localparam logic [7:0] TORCH_TABLE [TORCH_LEVELS] = '{
    8'h0C, 8'h17, 8'h23, 8'h31, 8'h3B, 8'h47, 8'h53
  };
  localparam logic [7:0] FLASH_TABLE [LEVEL_COUNT] = '{
    8'h03, 8'h05, 8'h08, 8'h0C, 8'h0E, 8'h12, 8'h14, 8'h19, 8'h1F, 8'h26,
    8'h2C, 8'h32, 8'h38, 8'h40, 8'h46, 8'h4C, 8'h53, 8'h59, 8'h5F, 8'h65,
    8'h6D, 8'h73, 8'h79, 8'h7F, 8'h86, 8'h8C, 8'h92, 8'h99
  };

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic out_stall = 1'b0;
  cmd_t in_data   = '0;
  logic in_stall;
  logic out_valid;
  rsp_t out_data;

  // Local copy of the controller state
  logic [7:0]  enable_img;
  logic [4:0]  level_q     [CHANNELS];
  logic [15:0] timeout_q   [CHANNELS];
  logic [15:0] countdown_q [CHANNELS];
  logic        running_q   [CHANNELS];

  rsp_t expected_rsp [$];
  int   mismatches    = 0;
  int   requests_sent = 0;
  int   rsp_checked   = 0;
  int   timer_expiries = 0;
  int   stall_left    = 0;
  bit   steady_flow   = 1'b0;

  dual_led_flash_torch_controller u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("dual_led_flash_torch_controller: mismatch");
    $finish;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [4:0] clamp_level(input logic signed [31:0] v);
    if (v < 0) return 5'd0;
    if (v >= LEVEL_COUNT) return 5'(LEVEL_COUNT - 1);
    return v[4:0];
  endfunction

  function automatic void led_on(input int ch);
    logic [7:0] bit_m;
    bit_m = ch ? EN_LED2 : EN_LED1;
    if (level_q[ch] < TORCH_LEVELS) enable_img = enable_img | EN_TORCH_MODE | bit_m;
    else enable_img = enable_img | EN_FLASH_MODE | bit_m;
  endfunction

  function automatic void led_off(input int ch);
    logic [7:0] bit_m;
    logic [7:0] other_m;
    bit_m   = ch ? EN_LED2 : EN_LED1;
    other_m = ch ? EN_LED1 : EN_LED2;
    // mode bits stay while the other LED is still lit
    if ((enable_img & other_m) != 0) enable_img = enable_img & ~bit_m;
    else enable_img = enable_img & ~(EN_FLASH_MODE | bit_m);
  endfunction

  function automatic rsp_t predict_response(input cmd_t req);
    rsp_t r;
    int   ch;
    bit   chan_ok;
    r       = '0;
    ch      = req.channel[0];
    chan_ok = (req.channel < CHANNELS);
    if (req.action == ACT_TICK) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (running_q[i]) begin
          countdown_q[i] = countdown_q[i] - 16'd1;
          if (countdown_q[i] == 16'd0) begin
            running_q[i] = 1'b0;
            led_off(i);
            timer_expiries++;
          end
        end
      end
    end else if (!chan_ok) begin
      r.status = STATUS_BAD_CHAN;
    end else begin
      case (req.action)
        ACT_SET_TIMEOUT: begin
          if (req.value < 0 || req.value > 65535) timeout_q[ch] = TIMEOUT_MAX;
          else timeout_q[ch] = req.value[15:0];
        end
        ACT_SET_LEVEL: level_q[ch] = clamp_level(req.value);
        ACT_ON: begin
          if (timeout_q[ch] != 16'd0) begin
            countdown_q[ch] = timeout_q[ch];
            running_q[ch]   = 1'b1;
          end
          led_on(ch);
        end
        ACT_OFF: begin
          led_off(ch);
          running_q[ch]   = 1'b0;
          countdown_q[ch] = 16'd0;
        end
        ACT_LEVEL_COUNT: r.reply = 11'(LEVEL_COUNT);
        ACT_MAX_TORCH:   r.reply = 11'(TORCH_LEVELS - 1);
        ACT_CURRENT:     r.reply = MA_TABLE[clamp_level(req.value)];
        ACT_HW_TIMEOUT:  r.reply = HW_TIMEOUT_MS;
        default:         r.status = STATUS_BAD_ACTION;
      endcase
    end
    r.enable_bits = enable_img;
    if (chan_ok) begin
      r.torch_code = (level_q[ch] < TORCH_LEVELS) ? TORCH_TABLE[level_q[ch]] : 8'h00;
      r.flash_code = FLASH_TABLE[level_q[ch]];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 30) $display("[%0t] response %0d: %s", $realtime, rsp_checked, msg);
    mismatches++;
  endtask

  task automatic send_request(input logic [3:0] act, input logic [1:0] ch,
                              input logic signed [31:0] v);
    cmd_t        req;
    int unsigned gap;
    req.action  = act;
    req.channel = ch;
    req.value   = v;
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_rsp.push_back(predict_response(req));
    requests_sent++;
    gap = (steady_flow || $urandom_range(0, 1)) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Receiver side stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0 && !steady_flow && $urandom_range(0, 99) < 30)
        stall_left = idle_len();
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_rsp
    rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rsp.size() == 0) begin
        report_mismatch("response with no request outstanding");
      end else begin
        want = expected_rsp.pop_front();
        rsp_checked++;
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_data.status, want.status));
        if (out_data.reply !== want.reply)
          report_mismatch($sformatf("reply %0d, want %0d", out_data.reply, want.reply));
        if (out_data.enable_bits !== want.enable_bits)
          report_mismatch($sformatf("enable_bits %h, want %h",
                                    out_data.enable_bits, want.enable_bits));
        if (out_data.torch_code !== want.torch_code)
          report_mismatch($sformatf("torch_code %h, want %h",
                                    out_data.torch_code, want.torch_code));
        if (out_data.flash_code !== want.flash_code)
          report_mismatch($sformatf("flash_code %h, want %h",
                                    out_data.flash_code, want.flash_code));
      end
    end
  end

  // Queries, clamping extremes, on/off mode bits, bad channel, unknown action
  task automatic test_command_decode();
    send_request(ACT_LEVEL_COUNT, 2'd0, 32'sd0);
    send_request(ACT_MAX_TORCH, 2'd1, 32'sd0);
    send_request(ACT_HW_TIMEOUT, 2'd0, -32'sd1);
    send_request(ACT_CURRENT, 2'd0, 32'sh8000_0000);
    send_request(ACT_CURRENT, 2'd1, 32'sh7FFF_FFFF);
    send_request(ACT_CURRENT, 2'd0, 32'sd27);
    send_request(ACT_SET_LEVEL, 2'd0, -32'sd5);
    send_request(ACT_SET_LEVEL, 2'd1, 32'sh7FFF_FFFF);
    send_request(ACT_ON, 2'd1, 32'sd0);
    send_request(ACT_ON, 2'd0, 32'sd0);
    send_request(ACT_OFF, 2'd1, 32'sd0);
    send_request(ACT_OFF, 2'd0, 32'sd0);
    send_request(ACT_SET_LEVEL, 2'd3, 32'sd5);
    send_request(ACT_ON, 2'd2, 32'sd0);
    send_request(4'(ACT_TICK + 7), 2'd0, 32'sd0);
    send_request(4'(ACT_TICK + 1), 2'd1, 32'sd0);
  endtask

  // Expiry, saturated timeouts, and turn on with a zero timeout
  task automatic test_countdown_expiry();
    send_request(ACT_SET_TIMEOUT, 2'd0, 32'sd1);
    send_request(ACT_SET_TIMEOUT, 2'd1, 32'sh0001_0000);
    send_request(ACT_SET_TIMEOUT, 2'd1, -32'sd7);
    send_request(ACT_SET_TIMEOUT, 2'd1, 32'sd2);
    send_request(ACT_ON, 2'd1, 32'sd0);
    send_request(ACT_ON, 2'd0, 32'sd0);
    send_request(ACT_TICK, 2'd2, 32'sd0);
    send_request(ACT_SET_TIMEOUT, 2'd1, 32'sd0);
    send_request(ACT_ON, 2'd1, 32'sd0);
    send_request(ACT_TICK, 2'd3, -32'sd1);
  endtask

  // Well-formed on/tick sequences with random content
  task automatic test_random_sessions(input int target);
    int               ch;
    int unsigned      r;
    logic signed [31:0] tval;
    logic signed [31:0] lval;
    while (requests_sent < target) begin
      ch = $urandom_range(0, 1);
      steady_flow = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 70) tval = $urandom_range(0, 6);
      else if (r < 85) tval = $urandom_range(7, 40);
      else if (r < 93) tval = -int'($urandom_range(1, 1000));
      else tval = $urandom;
      lval = ($urandom_range(0, 4) != 0) ? int'($urandom_range(0, 34)) - 3 : $urandom;
      send_request(ACT_SET_TIMEOUT, 2'(ch), tval);
      send_request(ACT_SET_LEVEL, 2'(ch), lval);
      send_request(ACT_ON, 2'(ch), $urandom);
      repeat ($urandom_range(1, 8)) begin
        r = $urandom_range(0, 99);
        if (r < 60) send_request(ACT_TICK, 2'($urandom_range(0, 3)), $urandom);
        else if (r < 70) send_request(ACT_ON, 2'(1 - ch), $urandom);
        else if (r < 80)
          send_request(ACT_CURRENT, 2'($urandom_range(0, 1)), int'($urandom_range(0, 34)) - 3);
        else if (r < 85) send_request(ACT_SET_LEVEL, 2'(1 - ch), $urandom_range(0, 27));
        else if (r < 90) send_request(ACT_SET_TIMEOUT, 2'(1 - ch), $urandom_range(0, 5));
        else send_request(ACT_OFF, 2'(ch), $urandom);
      end
      if ($urandom_range(0, 2) == 0) send_request(ACT_OFF, 2'($urandom_range(0, 1)), $urandom);
    end
    steady_flow = 1'b0;
  endtask

  // Unstructured requests over the full field ranges
  task automatic test_random_noise(input int target);
    while (requests_sent < target) begin
      if (requests_sent % 40 == 0) steady_flow = ($urandom_range(0, 2) == 0);
      send_request(4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)), $urandom);
    end
    steady_flow = 1'b0;
  endtask

  initial begin
    enable_img = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      level_q[i]     = '0;
      timeout_q[i]   = TIMEOUT_RESET;
      countdown_q[i] = '0;
      running_q[i]   = 1'b0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_command_decode();
    test_countdown_expiry();
    test_random_sessions(480);
    test_random_noise(660);

    in_valid <= 1'b0;
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Drove %0d requests (decode, countdown, sessions, random); checked %0d responses,",
             requests_sent, rsp_checked);
    $display("%0d countdown expiries predicted, %0d field mismatches.",
             timer_expiries, mismatches);
    if (mismatches == 0) begin
      $display("dual_led_flash_torch_controller: match");
    end else begin
      $display("dual_led_flash_torch_controller: mismatch");
    end
    $finish;
  end

endmodule
